[rtl/core/dcp_pkg.sv]
// Package for the dictionary 3-bit code packer.
// Holds the shared widths, register indexes and the result record type.
// No dependencies.
package dcp_pkg;

  localparam int unsigned DictSlots = 7;
  localparam int unsigned CodeW     = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned FillW     = 3;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = 2;
  localparam int unsigned FifoCntW  = 3;

  localparam logic [CodeW-1:0]   TermCode     = 3'd7;
  localparam logic [CfgIdxW-1:0] RegDictLen   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDictChar0 = 3'd1;

  typedef struct packed {
    logic [ByteW-1:0] packed_byte;
    logic             final_byte;
    logic             unmatched;
  } res_t;

endpackage

[rtl/core/dcp_in_if.sv]
// Input channel of the dictionary code packer: valid/ready plus one input item.
// Depends on dcp_pkg.
interface dcp_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [dcp_pkg::ByteW-1:0] symbol;

  modport source (output valid, action, symbol, input ready);
  modport sink (input valid, action, symbol, output ready);
endinterface

[rtl/core/dcp_out_if.sv]
// Output channel of the dictionary code packer: valid/ready plus one result item.
// Depends on dcp_pkg.
interface dcp_out_if;
  logic                     valid;
  logic                     ready;
  logic [dcp_pkg::ByteW-1:0] packed_byte;
  logic                     final_byte;
  logic                     unmatched;

  modport source (output valid, packed_byte, final_byte, unmatched, input ready);
  modport sink (input valid, packed_byte, final_byte, unmatched, output ready);
endinterface

[rtl/core/dcp_matcher.sv]
// Dictionary registers and the parallel symbol lookup.
// Depends on dcp_pkg.
module dcp_matcher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dcp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dcp_pkg::ByteW-1:0]   cfg_data_i,
  input  logic [dcp_pkg::ByteW-1:0]   symbol_i,
  output logic [dcp_pkg::CodeW-1:0]   code_o
);

  logic [dcp_pkg::CodeW-1:0] dict_len_q;
  logic [dcp_pkg::ByteW-1:0] dict_char_q [dcp_pkg::DictSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dict_len_q <= '0;
      for (int k = 0; k < dcp_pkg::DictSlots; k++) begin
        dict_char_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dcp_pkg::RegDictLen) begin
        dict_len_q <= cfg_data_i[dcp_pkg::CodeW-1:0];
      end else begin
        dict_char_q[cfg_idx_i - dcp_pkg::RegDictChar0] <= cfg_data_i;
      end
    end
  end

  // Scan from the top entry down so the lowest matching entry wins.
  always_comb begin
    code_o = dcp_pkg::TermCode;
    for (int k = dcp_pkg::DictSlots - 1; k >= 0; k--) begin
      if ((dcp_pkg::CodeW'(k) < dict_len_q) && (dict_char_q[k] == symbol_i)) begin
        code_o = dcp_pkg::CodeW'(k);
      end
    end
  end

endmodule

[rtl/core/dcp_packer.sv]
// Bit packer: keeps the partial byte and fill count and forms up to two results.
// Depends on dcp_pkg.
module dcp_packer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      action_i,
  input  logic [dcp_pkg::CodeW-1:0] code_i,
  output dcp_pkg::res_t             res0_o,
  output dcp_pkg::res_t             res1_o,
  output logic [1:0]                res_cnt_o
);

  logic [dcp_pkg::ByteW-1:0] partial_q, partial_d;
  logic [dcp_pkg::FillW-1:0] fill_q, fill_d;
  logic [dcp_pkg::CodeW-1:0] code;
  logic [2*dcp_pkg::ByteW-1:0] word;
  logic [dcp_pkg::FillW:0]   total;
  logic                      done;
  logic [dcp_pkg::ByteW-1:0] done_byte;
  logic [dcp_pkg::ByteW-1:0] next_partial;
  logic [dcp_pkg::FillW-1:0] next_fill;

  always_comb begin
    code  = action_i ? dcp_pkg::TermCode : code_i;
    word  = {partial_q, 8'h00} | (16'(code) << (4'd13 - {1'b0, fill_q}));
    total = {1'b0, fill_q} + 4'd3;
    done  = total >= 4'd8;
    done_byte = word[15:8];
    if (done) begin
      next_partial = word[7:0];
      next_fill    = dcp_pkg::FillW'(total - 4'd8);
    end else begin
      next_partial = word[15:8];
      next_fill    = total[dcp_pkg::FillW-1:0];
    end

    res1_o.packed_byte = next_partial;
    res1_o.final_byte  = 1'b1;
    res1_o.unmatched   = 1'b0;

    if (!action_i) begin
      res0_o.packed_byte = done_byte;
      res0_o.final_byte  = 1'b0;
      res0_o.unmatched   = code == dcp_pkg::TermCode;
      res_cnt_o          = {1'b0, done};
      partial_d          = next_partial;
      fill_d             = next_fill;
    end else begin
      // A flush sends a completed byte if there is one, then any leftover bits.
      res0_o.packed_byte = done ? done_byte : next_partial;
      res0_o.final_byte  = done ? (next_fill == '0) : 1'b1;
      res0_o.unmatched   = 1'b0;
      res_cnt_o          = (done && next_fill != '0) ? 2'd2 : 2'd1;
      partial_d          = '0;
      fill_d             = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      fill_q    <= '0;
    end else if (step_i) begin
      partial_q <= partial_d;
      fill_q    <= fill_d;
    end
  end

endmodule

[rtl/core/dcp_out_fifo.sv]
// Result queue: takes up to two result items a cycle and releases one a cycle while the receiver is ready.
// Depends on dcp_pkg.
module dcp_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_cnt_i,
  input  dcp_pkg::res_t       push0_i,
  input  dcp_pkg::res_t       push1_i,
  output logic                space2_o,
  output logic                valid_o,
  input  logic                pop_i,
  output dcp_pkg::res_t       head_o
);

  dcp_pkg::res_t               mem_q [dcp_pkg::FifoDepth];
  logic [dcp_pkg::FifoAw-1:0]  wr_ptr_q, wr_ptr_d;
  logic [dcp_pkg::FifoAw-1:0]  rd_ptr_q, rd_ptr_d;
  logic [dcp_pkg::FifoCntW-1:0] cnt_q, cnt_d;
  logic                        pop;

  assign valid_o  = cnt_q != '0;
  assign pop      = pop_i && valid_o;
  assign space2_o = cnt_q <= dcp_pkg::FifoCntW'(dcp_pkg::FifoDepth - 2);
  assign head_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + dcp_pkg::FifoAw'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + dcp_pkg::FifoAw'(pop);
    cnt_d    = cnt_q + dcp_pkg::FifoCntW'(push_cnt_i) - dcp_pkg::FifoCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + dcp_pkg::FifoAw'(1)] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[rtl/core/dictionary_3bit_code_packer_unit.sv]
// Dictionary 3-bit code packer. Each input item is either a symbol byte or an
// end-of-stream flush. A symbol is compared at once against up to seven
// dictionary characters and becomes the 3-bit code of the lowest matching
// entry, or 7 if none matches. Codes are packed MSB first into bytes, and a
// byte is sent as soon as it is complete; its unmatched flag is set when the
// symbol that completed it was not in the dictionary. A flush appends the
// terminator code 7, sends what remains padded with zeros (one or two items,
// the last marked final_byte), and empties the packer. An item is registered
// when accepted, then coded, packed and written into the result queue, whose
// head drives the output, once the queue has room for two results. The block
// takes one item per cycle while there is that room; the two bytes of a flush
// leave one at a time through the single output port, which the four-entry queue absorbs.
// Dictionary registers must be written only while no items are in flight.
// Depends on dcp_pkg, dcp_in_if, dcp_out_if, dcp_matcher, dcp_packer and
// dcp_out_fifo.
module dictionary_3bit_code_packer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dcp_in_if.sink                      in_i,
  dcp_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [dcp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dcp_pkg::ByteW-1:0]   cfg_data_i
);

  // Input register stage.
  logic                       in_valid_q;
  logic                       action_q;
  logic [dcp_pkg::ByteW-1:0]  symbol_q;

  logic                       fire;
  logic                       space2;
  logic [dcp_pkg::CodeW-1:0]  code;
  dcp_pkg::res_t              res0;
  dcp_pkg::res_t              res1;
  logic [1:0]                 res_cnt;
  logic [1:0]                 push_cnt;
  dcp_pkg::res_t              head;

  // The held item is processed whenever the queue has room for two results.
  assign fire        = in_valid_q && space2;
  assign in_i.ready  = !in_valid_q || fire;
  assign push_cnt    = fire ? res_cnt : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      action_q <= in_i.action;
      symbol_q <= in_i.symbol;
    end
  end

  dcp_matcher u_matcher (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .symbol_i   (symbol_q),
    .code_o     (code)
  );

  dcp_packer u_packer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (fire),
    .action_i  (action_q),
    .code_i    (code),
    .res0_o    (res0),
    .res1_o    (res1),
    .res_cnt_o (res_cnt)
  );

  dcp_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .space2_o   (space2),
    .valid_o    (out_o.valid),
    .pop_i      (out_o.ready),
    .head_o     (head)
  );

  assign out_o.packed_byte = head.packed_byte;
  assign out_o.final_byte  = head.final_byte;
  assign out_o.unmatched   = head.unmatched;

endmodule

[tb/tb_dictionary_3bit_code_packer_unit.sv]
// Self-checking testbench for dictionary_3bit_code_packer_unit, with its own model of the packer.
// Needs dcp_pkg, dcp_in_if, dcp_out_if and the RTL of the block; nothing else.
module tb_dictionary_3bit_code_packer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfPeriod   = 5;
  localparam int unsigned ResetCycles  = 3;
  // An item is registered, then packed, then shown on the output; the settle wait must cover that path.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned PhaseItems   = 250;
  localparam int unsigned IdleSpan     = 60;

  // The four idling modes that the random part rotates through.
  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  // The scoreboard keeps its own copy of the dictionary and of the partial byte.
  // Each accepted input item is packed here, and the bytes that it completes are
  // queued in order so that the output monitor can compare them one at a time.
  class packer_scoreboard;
    logic [dcp_pkg::CfgIdxW-1:0] dict_len;
    logic [dcp_pkg::ByteW-1:0]   dict_chars [dcp_pkg::DictSlots];
    logic [dcp_pkg::ByteW-1:0]   partial;
    logic [dcp_pkg::FillW-1:0]   fill;
    dcp_pkg::res_t               pending_bytes [$];
    int unsigned                 errors;

    function new();
      dict_len = '0;
      foreach (dict_chars[k]) dict_chars[k] = '0;
      partial = '0;
      fill = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [dcp_pkg::CfgIdxW-1:0] idx, logic [dcp_pkg::ByteW-1:0] data);
      if (idx == dcp_pkg::RegDictLen) begin
        dict_len = data[dcp_pkg::CfgIdxW-1:0];
      end else begin
        dict_chars[idx - dcp_pkg::RegDictChar0] = data;
      end
    endfunction

    function void note_input(logic act, logic [dcp_pkg::ByteW-1:0] sym);
      logic [dcp_pkg::CodeW-1:0]   code;
      logic [2*dcp_pkg::ByteW-1:0] word;
      dcp_pkg::res_t               outs [2];
      int                          total;
      int                          n;
      int                          k;
      code = dcp_pkg::TermCode;
      n = 0;
      // The lowest valid entry that matches wins, so scan from the top down.
      if (!act) begin
        for (k = dcp_pkg::DictSlots - 1; k >= 0; k--) begin
          if (k < dict_len && dict_chars[k] == sym) code = dcp_pkg::CodeW'(k);
        end
      end
      // The new code goes just below the bits already held, MSB first.
      word = {partial, {dcp_pkg::ByteW{1'b0}}} | (16'(code) << (13 - fill));
      total = int'(fill) + dcp_pkg::CodeW;
      if (total >= dcp_pkg::ByteW) begin
        outs[0].packed_byte = word[2*dcp_pkg::ByteW-1:dcp_pkg::ByteW];
        outs[0].final_byte = 1'b0;
        outs[0].unmatched = !act && (code == dcp_pkg::TermCode);
        n = 1;
        partial = word[dcp_pkg::ByteW-1:0];
        fill = dcp_pkg::FillW'(total - dcp_pkg::ByteW);
      end else begin
        partial = word[2*dcp_pkg::ByteW-1:dcp_pkg::ByteW];
        fill = dcp_pkg::FillW'(total);
      end
      // A flush sends any remaining bits padded with zeros and marks its last byte.
      if (act) begin
        if (fill != 0) begin
          outs[n].packed_byte = partial;
          outs[n].final_byte = 1'b0;
          outs[n].unmatched = 1'b0;
          n++;
        end
        outs[n-1].final_byte = 1'b1;
        partial = '0;
        fill = '0;
      end
      for (k = 0; k < n; k++) pending_bytes.push_back(outs[k]);
    endfunction

    function void check_result(dcp_pkg::res_t got);
      dcp_pkg::res_t want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual byte=%02h final=%0b unm=%0b",
                 $time, got.packed_byte, got.final_byte, got.unmatched);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected byte=%02h final=%0b unm=%0b,",
                   $time, want.packed_byte, want.final_byte, want.unmatched,
                   " actual byte=%02h final=%0b unm=%0b",
                   got.packed_byte, got.final_byte, got.unmatched);
          errors++;
        end
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we;
  logic [dcp_pkg::CfgIdxW-1:0] cfg_idx;
  logic [dcp_pkg::ByteW-1:0]   cfg_data;
  int unsigned                 src_idle_pct;
  int unsigned                 sink_stall_pct;
  int unsigned                 cycle_count;
  packer_scoreboard            board;

  dcp_in_if  in_ch ();
  dcp_out_if out_ch ();

  dictionary_3bit_code_packer_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // The receiver decides its ready once per falling edge, so that it is stable
  // when the rising edge samples the handshake.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Every accepted result item goes straight to the scoreboard. The values read
  // here are the ones that were present just before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      board.check_result(dcp_pkg::res_t'({out_ch.packed_byte, out_ch.final_byte,
                                          out_ch.unmatched}));
    end
  end

  // A hung block must not hold the run forever.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item was taken.
  // While idle the valid is low; valid is set once per step at most.
  task automatic send_item(logic act, logic [dcp_pkg::ByteW-1:0] sym);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.action <= logic'($urandom_range(1));
      in_ch.symbol <= dcp_pkg::ByteW'($urandom_range(255));
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.symbol <= sym;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.note_input(act, sym);
    @(negedge clk_i);
  endtask

  // Waits until every expected byte has come out and the pipeline has emptied.
  // Symbols that complete no byte may still be in flight, hence the extra cycles.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (board.pending_bytes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Writes the length and all seven characters, one register per cycle.
  task automatic write_dictionary(logic [dcp_pkg::CfgIdxW-1:0] len,
                                  logic [dcp_pkg::ByteW-1:0] chars [dcp_pkg::DictSlots]);
    int k;
    cfg_we <= 1'b1;
    cfg_idx <= dcp_pkg::RegDictLen;
    cfg_data <= dcp_pkg::ByteW'(len);
    board.set_reg(dcp_pkg::RegDictLen, dcp_pkg::ByteW'(len));
    @(negedge clk_i);
    for (k = 0; k < dcp_pkg::DictSlots; k++) begin
      cfg_idx <= dcp_pkg::RegDictChar0 + dcp_pkg::CfgIdxW'(k);
      cfg_data <= chars[k];
      board.set_reg(dcp_pkg::RegDictChar0 + dcp_pkg::CfgIdxW'(k), chars[k]);
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    logic [dcp_pkg::ByteW-1:0]   chars [dcp_pkg::DictSlots];
    logic [dcp_pkg::CfgIdxW-1:0] phase_len [NumPhases];
    logic [dcp_pkg::ByteW-1:0]   sym;
    logic                        act;
    idle_mode_e                  mode;
    int                          p;
    int                          n;
    int                          k;

    board = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cycle_count = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.symbol = '0;
    out_ch.ready = 1'b0;

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, first with the dictionary as it comes out of reset (empty).
    // A flush on an empty packer sends the terminator alone. With no entries every
    // symbol is unmatched, so the third symbol completes a byte with the flag set.
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h3C);
    send_item(1'b1, 8'hFF);
    wait_idle();

    // A full dictionary holding both extreme characters and one duplicate pair.
    chars = '{8'h00, 8'hFF, 8'h41, 8'h41, 8'h5A, 8'h80, 8'h7F};
    write_dictionary(3'd7, chars);
    // Codes 0 to 6 once but 3 (the duplicate, which must take the lower code), and one miss.
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h41);
    send_item(1'b0, 8'h5A);
    send_item(1'b0, 8'h80);
    send_item(1'b0, 8'h7F);
    send_item(1'b0, 8'h13);
    send_item(1'b0, 8'h41);
    send_item(1'b1, 8'h00);
    // Two codes leave six bits, so the flush needs two bytes.
    send_item(1'b0, 8'h7F);
    send_item(1'b0, 8'h7F);
    send_item(1'b1, 8'h7F);
    // Seven bits held: the terminator spills into a second byte.
    send_item(1'b0, 8'h5A);
    send_item(1'b0, 8'h55);
    send_item(1'b0, 8'h80);
    send_item(1'b0, 8'hAA);
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'h00);
    wait_idle();

    // Random part: several dictionary settings, from empty to full. Most symbols are
    // taken from the current characters, including slots past the valid length.
    phase_len = '{3'd7, 3'd0, 3'd1, 3'd3, 3'd7, 3'd5};
    for (p = 0; p < NumPhases; p++) begin
      for (k = 0; k < dcp_pkg::DictSlots; k++) chars[k] = dcp_pkg::ByteW'($urandom_range(255));
      if (p == 3) chars[2] = chars[0];
      if (p == 4) begin
        chars[0] = 8'h00;
        chars[6] = 8'hFF;
      end
      write_dictionary(phase_len[p], chars);
      for (n = 0; n < PhaseItems; n++) begin
        // Idling changes every few dozen items so that gaps land on every state.
        mode = idle_mode_e'((n / IdleSpan + p) % 4);
        case (mode)
          IdleNone: begin
            src_idle_pct = 0;
            sink_stall_pct = 0;
          end
          IdleSender: begin
            src_idle_pct = 53;
            sink_stall_pct = 0;
          end
          IdleReceiver: begin
            src_idle_pct = 0;
            sink_stall_pct = 53;
          end
          default: begin
            src_idle_pct = 25;
            sink_stall_pct = 25;
          end
        endcase
        act = ($urandom_range(11) == 0);
        if ($urandom_range(9) < 7) begin
          sym = chars[$urandom_range(dcp_pkg::DictSlots - 1)];
        end else begin
          sym = dcp_pkg::ByteW'($urandom_range(255));
        end
        send_item(act, sym);
      end
      // Leave the packer empty before the dictionary changes.
      send_item(1'b1, 8'h00);
      wait_idle();
    end

    src_idle_pct = 0;
    sink_stall_pct = 0;
    wait_idle();
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
